FILE: hdl/hpt_pkg.sv
// Shared constants and types for the homogeneous point transform.
// Used by every module of the block; depends on nothing.
`default_nettype none

package hpt_pkg;

  // Fixed-point format and matrix shape.
  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 32;
  localparam int MAT_DIM     = 4;
  localparam int MAT_SIZE    = MAT_DIM * MAT_DIM;
  localparam int IDX_W       = $clog2(MAT_SIZE);
  localparam int NUM_LANES   = MAT_DIM - 1;

  // Widths of products, exact row sums and their magnitudes.
  localparam int PROD_W      = 2 * DATA_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam int MAG_W       = PROD_W;
  localparam int HI_SHIFT    = DATA_W - FRAC_BITS;

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [DATA_W-1:0] FX_ONE = DATA_W'(64'd1 << FRAC_BITS);

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_XFORM = 1'b1
  } cmd_t;

  // Four exact row sums of one transformed point, w last.
  typedef logic [MAT_DIM-1:0][SUM_W-1:0] sums_t;

  // Magnitude stage: divisor magnitude and per-lane numerator magnitudes.
  typedef struct packed {
    logic                            vld;
    logic                            zero;
    logic [MAG_W-1:0]                dm;
    logic [NUM_LANES-1:0]            neg;
    logic [NUM_LANES-1:0][MAG_W-1:0] nm;
  } mag_stage_t;

  // One coordinate inside the divider pipeline.
  typedef struct packed {
    logic              neg;
    logic              ovf;
    logic [MAG_W-1:0]  rem;
    logic [DATA_W-1:0] low;
    logic [DATA_W-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic                        vld;
    logic                        zero;
    logic [MAG_W-1:0]            dm;
    lane_t [NUM_LANES-1:0]       ln;
  } div_stage_t;

endpackage

`default_nettype wire

FILE: hdl/hpt_front.sv
// Front part: takes input beats, keeps the matrix store, forms exact row sums.
// Depends on hpt_pkg.
`default_nettype none

module hpt_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_command,
  input  logic [hpt_pkg::IDX_W-1:0]   in_matrix_index,
  input  logic signed [hpt_pkg::DATA_W-1:0] in_matrix_value,
  input  logic signed [hpt_pkg::DATA_W-1:0] in_point_x,
  input  logic signed [hpt_pkg::DATA_W-1:0] in_point_y,
  input  logic signed [hpt_pkg::DATA_W-1:0] in_point_z,
  output logic                        push,
  output hpt_pkg::sums_t              push_data,
  input  logic                        queue_full
);
  import hpt_pkg::*;

  logic signed [DATA_W-1:0] mat_r [MAT_SIZE];
  logic signed [DATA_W-1:0] pt [NUM_LANES];
  logic signed [PROD_W-1:0] prod_r [MAT_DIM][NUM_LANES];
  logic signed [DATA_W-1:0] off_r [MAT_DIM];
  sums_t                    sums_r;
  sums_t                    sums_nxt;
  logic                     f1_vld_r, f2_vld_r;
  logic                     adv, accept, wr_en, xf_en;

  // The front moves as one unit unless a finished sum cannot enter the queue.
  assign adv      = !(f2_vld_r && queue_full);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign wr_en    = accept && (in_command == CMD_WRITE);
  assign xf_en    = accept && (in_command == CMD_XFORM);
  assign push     = f2_vld_r && adv;
  assign push_data = sums_r;

  assign pt[0] = in_point_x;
  assign pt[1] = in_point_y;
  assign pt[2] = in_point_z;

  // Matrix store; reset loads the identity.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAT_SIZE; i++) begin
        mat_r[i] <= ((i / MAT_DIM) == (i % MAT_DIM)) ? FX_ONE : '0;
      end
    end else if (wr_en) begin
      mat_r[in_matrix_index] <= in_matrix_value;
    end
  end

  // Valid bits of the two front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
    end else if (adv) begin
      f1_vld_r <= xf_en;
      f2_vld_r <= f1_vld_r;
    end
  end

  // Stage one: the twelve matrix-by-coordinate products and the offsets.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < MAT_DIM; r++) begin
        for (int c = 0; c < NUM_LANES; c++) begin
          prod_r[r][c] <= PROD_W'(mat_r[r * MAT_DIM + c]) * PROD_W'(pt[c]);
        end
        off_r[r] <= mat_r[r * MAT_DIM + NUM_LANES];
      end
    end
  end

  // Stage two: exact row sums, the offset scaled by one in fixed point.
  always_comb begin
    for (int r = 0; r < MAT_DIM; r++) begin
      sums_nxt[r] = SUM_W'(prod_r[r][0]) + SUM_W'(prod_r[r][1]) + SUM_W'(prod_r[r][2])
                  + (SUM_W'(off_r[r]) <<< FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sums_r <= sums_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/hpt_queue.sv
// Short queue of row-sum beats between the front and back parts.
// Depends on hpt_pkg.
`default_nettype none

module hpt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hpt_pkg::sums_t push_data,
  output logic           full,
  input  logic           pop,
  output hpt_pkg::sums_t pop_data,
  output logic           empty
);
  import hpt_pkg::*;

  sums_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/hpt_back.sv
// Back part: sign/magnitude split, pipelined restoring divide, saturation.
// Depends on hpt_pkg.
`default_nettype none

module hpt_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             queue_empty,
  input  hpt_pkg::sums_t                   head,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [hpt_pkg::DATA_W-1:0] out_x,
  output logic signed [hpt_pkg::DATA_W-1:0] out_y,
  output logic signed [hpt_pkg::DATA_W-1:0] out_z,
  output logic                             out_zero_divisor
);
  import hpt_pkg::*;

  localparam int NSTG = DATA_W;

  mag_stage_t        b1_r, b1_nxt;
  div_stage_t        stg_r   [NSTG+1];
  div_stage_t        stg_nxt [NSTG+1];
  logic [DATA_W-1:0] res [NUM_LANES];
  logic              adv;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_x_r, out_y_r, out_z_r;
  logic              out_zero_r;

  // Magnitude of a signed row sum.
  function automatic logic [MAG_W-1:0] fx_mag(input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] t;
    t = v[SUM_W-1] ? (~v + 1'b1) : v;
    return t[MAG_W-1:0];
  endfunction

  // One restoring-division step: one quotient bit.
  function automatic lane_t div_step(input lane_t l, input logic [MAG_W-1:0] dm);
    logic [MAG_W:0]   trial;
    logic [MAG_W+1:0] diff;
    lane_t            o;
    trial = {l.rem, l.low[DATA_W-1]};
    diff  = {1'b0, trial} - {2'b00, dm};
    o     = l;
    o.rem = diff[MAG_W+1] ? trial[MAG_W-1:0] : diff[MAG_W-1:0];
    o.low = l.low << 1;
    o.quo = {l.quo[DATA_W-2:0], ~diff[MAG_W+1]};
    return o;
  endfunction

  // Saturate, apply the sign, force zero on a zero divisor.
  function automatic logic [DATA_W-1:0] fx_sat(input lane_t l, input logic zero);
    logic [DATA_W-1:0] lim;
    logic [DATA_W-1:0] sat;
    lim = l.neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    sat = (l.ovf || (l.quo > lim)) ? lim : l.quo;
    if (zero) begin
      return '0;
    end
    return l.neg ? (~sat + 1'b1) : sat;
  endfunction

  // The whole back pipeline holds only while a result waits at the output.
  assign adv = !(out_valid_r && out_stall);
  assign pop = !queue_empty && adv;

  // Sign and magnitude of numerators and divisor.
  always_comb begin
    b1_nxt      = '0;
    b1_nxt.vld  = pop;
    b1_nxt.zero = (head[MAT_DIM-1] == '0);
    b1_nxt.dm   = fx_mag(head[MAT_DIM-1]);
    for (int k = 0; k < NUM_LANES; k++) begin
      b1_nxt.neg[k] = head[k][SUM_W-1] ^ head[MAT_DIM-1][SUM_W-1];
      b1_nxt.nm[k]  = fx_mag(head[k]);
    end
  end

  // Divider setup: the scaled numerator is nm shifted up by FRAC_BITS; its part
  // above the quotient width is the starting remainder and decides overflow.
  always_comb begin
    stg_nxt[0]      = '0;
    stg_nxt[0].vld  = b1_r.vld;
    stg_nxt[0].zero = b1_r.zero;
    stg_nxt[0].dm   = b1_r.dm;
    for (int k = 0; k < NUM_LANES; k++) begin
      stg_nxt[0].ln[k].neg = b1_r.neg[k];
      stg_nxt[0].ln[k].rem = b1_r.nm[k] >> HI_SHIFT;
      stg_nxt[0].ln[k].ovf = ((b1_r.nm[k] >> HI_SHIFT) >= b1_r.dm);
      stg_nxt[0].ln[k].low = DATA_W'(b1_r.nm[k] << FRAC_BITS);
      stg_nxt[0].ln[k].quo = '0;
    end
  end

  // Divider stages, one quotient bit per stage for each coordinate.
  always_comb begin
    for (int s = 1; s <= NSTG; s++) begin
      stg_nxt[s] = stg_r[s-1];
      for (int k = 0; k < NUM_LANES; k++) begin
        stg_nxt[s].ln[k] = div_step(stg_r[s-1].ln[k], stg_r[s-1].dm);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_r.vld <= 1'b0;
      for (int s = 0; s <= NSTG; s++) begin
        stg_r[s].vld <= 1'b0;
      end
    end else if (adv) begin
      b1_r <= b1_nxt;
      for (int s = 0; s <= NSTG; s++) begin
        stg_r[s] <= stg_nxt[s];
      end
    end
  end

  // Final results of the last divider stage.
  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      res[k] = fx_sat(stg_r[NSTG].ln[k], stg_r[NSTG].zero);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= stg_r[NSTG].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && stg_r[NSTG].vld) begin
      out_x_r    <= res[0];
      out_y_r    <= res[1];
      out_z_r    <= res[2];
      out_zero_r <= stg_r[NSTG].zero;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_x            = out_x_r;
  assign out_y            = out_y_r;
  assign out_z            = out_z_r;
  assign out_zero_divisor = out_zero_r;

endmodule

`default_nettype wire

FILE: hdl/homogeneous_point_transform_top.sv
// Top level of the homogeneous 4x4 point transform with perspective divide.
// Depends on hpt_pkg, hpt_front, hpt_queue and hpt_back.
//
// Usage: each input beat carries a command. A write beat stores one Q16.16
// matrix element at a row-major index and gives no result. A transform beat
// multiplies (x, y, z, 1) by the stored matrix and divides x, y and z by w;
// it gives one result beat with saturated Q16.16 coordinates and a flag that
// is set, with zero coordinates, when w is exactly zero.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. A write takes effect for every transform beat after it.
// From an accepted transform beat to its result beat, the path runs through
// two front stages (products, row sums), the queue, the magnitude stage, the
// divider setup stage, 32 restoring-division stages and the output register.
// The divider is fully pipelined: one beat per cycle while in_stall is low.
// When the receiver stalls, the back part holds; the four-entry queue keeps
// taking beats from the front until it fills, then in_stall rises.
// Reset is synchronous and active low; it loads the identity matrix and
// empties the pipeline and queue.
`default_nettype none

module homogeneous_point_transform_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_command,
  input  logic [hpt_pkg::IDX_W-1:0]         in_matrix_index,
  input  logic signed [hpt_pkg::DATA_W-1:0] in_matrix_value,
  input  logic signed [hpt_pkg::DATA_W-1:0] in_point_x,
  input  logic signed [hpt_pkg::DATA_W-1:0] in_point_y,
  input  logic signed [hpt_pkg::DATA_W-1:0] in_point_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [hpt_pkg::DATA_W-1:0] out_x,
  output logic signed [hpt_pkg::DATA_W-1:0] out_y,
  output logic signed [hpt_pkg::DATA_W-1:0] out_z,
  output logic                              out_zero_divisor
);
  import hpt_pkg::*;

  logic  push, queue_full, pop, queue_empty;
  sums_t push_data, head;

  hpt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_matrix_index (in_matrix_index),
    .in_matrix_value (in_matrix_value),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_point_z      (in_point_z),
    .push            (push),
    .push_data       (push_data),
    .queue_full      (queue_full)
  );

  hpt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (queue_empty)
  );

  hpt_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .queue_empty      (queue_empty),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_z            (out_z),
    .out_zero_divisor (out_zero_divisor)
  );

endmodule

`default_nettype wire

FILE: hdl/hpt_checker.sv
// Port-level checks for the point transform, bound to the top level.
// Depends on hpt_pkg and homogeneous_point_transform_top.
`default_nettype none

module hpt_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [hpt_pkg::DATA_W-1:0] out_x,
  input logic signed [hpt_pkg::DATA_W-1:0] out_y,
  input logic signed [hpt_pkg::DATA_W-1:0] out_z,
  input logic                              out_zero_divisor
);

  // Reset empties the result side.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  // A zero divisor always comes with zero coordinates.
  a_zero_coords: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_divisor) |-> (out_x == '0 && out_y == '0 && out_z == '0))
    else $error("zero divisor result with nonzero coordinates");

  // A stalled result beat stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result beat dropped under stall");

  // A stalled result beat keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_x) && $stable(out_y) && $stable(out_z)
                                  && $stable(out_zero_divisor)))
    else $error("result payload changed under stall");

endmodule

bind homogeneous_point_transform_top hpt_checker u_hpt_checker (.*);

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for homogeneous_point_transform_top.
// Depends on hpt_pkg and the block's RTL; predicts results with its own model.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import hpt_pkg::*;

  typedef struct {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
    logic              zdiv;
  } point_res_t;

  typedef struct {
    cmd_t              cmd;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] val;
    logic [DATA_W-1:0] px;
    logic [DATA_W-1:0] py;
    logic [DATA_W-1:0] pz;
    bit                typed_in;
    point_res_t        want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_command = 1'b0;
  logic [IDX_W-1:0] in_matrix_index = '0;
  logic signed [DATA_W-1:0] in_matrix_value = '0;
  logic signed [DATA_W-1:0] in_point_x = '0;
  logic signed [DATA_W-1:0] in_point_y = '0;
  logic signed [DATA_W-1:0] in_point_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_x;
  logic signed [DATA_W-1:0] out_y;
  logic signed [DATA_W-1:0] out_z;
  logic out_zero_divisor;

  logic [DATA_W-1:0] model_matrix [MAT_SIZE];
  point_res_t pending_points[$];
  point_res_t typed_points[$];
  bit typed_flags[$];
  int errors = 0;
  bit quiet_tail = 1'b0;
  bit hold_sink = 1'b0;

  homogeneous_point_transform_top dut (.*);

  // Clock: 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit.
  initial begin
    #20ms;
    $display("homogeneous_point_transform_top verification failed");
    $finish;
  end

  // Truncating fixed-point divide of num * 2^F by den, saturated to 32 bits.
  function automatic logic [DATA_W-1:0] fx_quot(logic signed [127:0] num,
                                                logic signed [127:0] den);
    logic signed [127:0] q;
    q = (num <<< FRAC_BITS) / den;
    if (q > 128'sh7FFFFFFF) return 32'h7FFFFFFF;
    if (q < -128'sh80000000) return 32'h80000000;
    return q[DATA_W-1:0];
  endfunction

  // Transform a point by the predicted matrix and apply the divide.
  function automatic point_res_t project_point(logic [DATA_W-1:0] px,
                                               logic [DATA_W-1:0] py,
                                               logic [DATA_W-1:0] pz);
    logic signed [127:0] acc [MAT_DIM];
    point_res_t r;
    for (int row = 0; row < MAT_DIM; row++) begin
      acc[row] = 128'(signed'(model_matrix[row*4]))   * 128'(signed'(px))
               + 128'(signed'(model_matrix[row*4+1])) * 128'(signed'(py))
               + 128'(signed'(model_matrix[row*4+2])) * 128'(signed'(pz))
               + (128'(signed'(model_matrix[row*4+3])) <<< FRAC_BITS);
    end
    if (acc[3] == 0) begin
      r = '{x: '0, y: '0, z: '0, zdiv: 1'b1};
    end else begin
      r.x = fx_quot(acc[0], acc[3]);
      r.y = fx_quot(acc[1], acc[3]);
      r.z = fx_quot(acc[2], acc[3]);
      r.zdiv = 1'b0;
    end
    return r;
  endfunction

  // Offer one beat and update the prediction when it is accepted.
  task automatic send_beat(stim_row_t s);
    in_valid <= 1'b1;
    in_command <= s.cmd;
    in_matrix_index <= s.idx;
    in_matrix_value <= s.val;
    in_point_x <= s.px;
    in_point_y <= s.py;
    in_point_z <= s.pz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (s.cmd == CMD_WRITE) begin
      model_matrix[s.idx] = s.val;
    end else begin
      pending_points.push_back(project_point(s.px, s.py, s.pz));
      typed_points.push_back(s.want);
      typed_flags.push_back(s.typed_in);
    end
  endtask

  task automatic sender_gap();
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return FX_ONE;
      3: return -FX_ONE;
      4: return $urandom_range(0, 32'h7FFFF) - 32'h40000;
      default: return $urandom;
    endcase
  endfunction

  function automatic stim_row_t rand_write(logic [IDX_W-1:0] idx);
    stim_row_t s;
    s = '{cmd: CMD_WRITE, idx: idx, val: rand_word(), px: $urandom,
          py: $urandom, pz: $urandom, typed_in: 0, want: '{0, 0, 0, 0}};
    return s;
  endfunction

  function automatic stim_row_t rand_point();
    stim_row_t s;
    s = '{cmd: CMD_XFORM, idx: IDX_W'($urandom), val: $urandom, px: rand_word(),
          py: rand_word(), pz: rand_word(), typed_in: 0, want: '{0, 0, 0, 0}};
    return s;
  endfunction

  // Receiver: random stalls, long holds, and checks of every beat.
  always @(posedge clk) begin
    point_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = pending_points.pop_front();
        if (typed_flags.pop_front()) e = typed_points.pop_front();
        else void'(typed_points.pop_front());
        if (out_x !== e.x) begin
          $error("out_x expected %h actual %h", e.x, out_x); errors++;
        end
        if (out_y !== e.y) begin
          $error("out_y expected %h actual %h", e.y, out_y); errors++;
        end
        if (out_z !== e.z) begin
          $error("out_z expected %h actual %h", e.z, out_z); errors++;
        end
        if (out_zero_divisor !== e.zdiv) begin
          $error("out_zero_divisor expected %b actual %b", e.zdiv,
                 out_zero_divisor);
          errors++;
        end
      end
    end
  end

  initial begin : sink_stall
    int burst;
    @(posedge rst_n);
    forever begin
      if (hold_sink) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        out_stall <= 1'b0;
        hold_sink = 1'b0;
        @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  // Main stimulus.
  initial begin : stimulus
    stim_row_t directed[$];
    stim_row_t s;
    logic [DATA_W-1:0] mx = 32'h7FFFFFFF;
    logic [DATA_W-1:0] mn = 32'h80000000;
    int waited;

    for (int i = 0; i < MAT_SIZE; i++)
      model_matrix[i] = (i % 5 == 0) ? FX_ONE : '0;

    // Identity after reset passes points straight through.
    directed.push_back('{CMD_XFORM, 4'hF, mx, FX_ONE, -FX_ONE, mn, 1,
                        '{FX_ONE, -FX_ONE, mn, 1'b0}});
    directed.push_back('{CMD_XFORM, 4'h0, mn, mx, mn, '0, 1, '{mx, mn, '0, 1'b0}});
    // Zero w row gives the zero-divisor flag.
    directed.push_back('{CMD_WRITE, 4'd15, '0, mx, mx, mx, 0, '{0, 0, 0, 0}});
    directed.push_back('{CMD_XFORM, 4'h3, '1, 32'h1234, 32'h5678, 32'h9ABC, 1,
                        '{'0, '0, '0, 1'b1}});
    // Tiny w saturates the quotients both ways.
    directed.push_back('{CMD_WRITE, 4'd15, 32'h1, '0, '0, '0, 0, '{0, 0, 0, 0}});
    directed.push_back('{CMD_XFORM, 4'h0, '0, mx, mn, '0, 1, '{mx, mn, '0, 1'b0}});
    // Negative w, extreme elements, truncation rows via the predictor.
    directed.push_back('{CMD_WRITE, 4'd15, -32'sd3 <<< 16, '0, '0, '0, 0, '{0, 0, 0, 0}});
    directed.push_back('{CMD_XFORM, 4'h0, '0, 32'h10000, 32'h20000, -32'sd1, 0,
                        '{0, 0, 0, 0}});
    directed.push_back('{CMD_WRITE, 4'd3, mx, '0, '0, '0, 0, '{0, 0, 0, 0}});
    directed.push_back('{CMD_WRITE, 4'd12, mn, '0, '0, '0, 0, '{0, 0, 0, 0}});
    directed.push_back('{CMD_WRITE, 4'd6, mn, '0, '0, '0, 0, '{0, 0, 0, 0}});
    directed.push_back('{CMD_XFORM, 4'h0, '0, mx, mx, mx, 0, '{0, 0, 0, 0}});
    directed.push_back('{CMD_XFORM, 4'h0, '0, mn, mn, mn, 0, '{0, 0, 0, 0}});
    directed.push_back('{CMD_XFORM, 4'h0, '0, 32'h5, 32'hFFFFFFFB, 32'h7, 0,
                        '{0, 0, 0, 0}});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_beat(directed[i]);
      sender_gap();
    end

    // Random part: matrix loads followed by point bursts.
    for (int n = 0; n < 480; ) begin
      if ($urandom_range(0, 9) == 0) begin
        s = rand_write(IDX_W'($urandom));
        send_beat(s);
        n++;
      end else if ($urandom_range(0, 5) == 0) begin
        for (int i = 0; i < MAT_SIZE; i++) begin
          send_beat(rand_write(i[IDX_W-1:0]));
          sender_gap();
        end
        n += MAT_SIZE;
      end else begin
        send_beat(rand_point());
        n++;
      end
      sender_gap();
      if (n > 150 && n < 170) hold_sink = 1'b1;
      if (n > 300 && n < 320 && pending_points.size() != 0) begin
        // Pause until the pipeline drains.
        in_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge clk);
      end
      if (n > 420) quiet_tail = 1'b1;
    end
    in_valid <= 1'b0;

    waited = 0;
    while (pending_points.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (pending_points.size() != 0) begin
      $error("%0d results never arrived", pending_points.size());
      errors++;
    end
    if (errors == 0) begin
      $display("homogeneous_point_transform_top verification clean");
    end else begin
      $display("homogeneous_point_transform_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
